// ----- src/stepper_step_dir_executor_macros.svh -----
// Assertion macros shared by the checker of the step/direction executor.
// Depends on nothing; taken in by `include where assertions are written.
`ifndef STEPPER_STEP_DIR_EXECUTOR_MACROS_SVH
`define STEPPER_STEP_DIR_EXECUTOR_MACROS_SVH

// same-cycle implication
`define SDE_ASSERT_NOW(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sde assertion failed");

// next-cycle implication
`define SDE_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sde assertion failed");

`endif

// ----- src/sde_pkg.sv -----
// Package of the step/direction executor: widths, register codes, item structs.
// Used by every RTL file of the block; depends on nothing.
package sde_pkg;

   localparam int AXIS_COUNT   = 4;
   localparam int REPEAT_LIMIT = 64;

   localparam int PIN_W      = 5;
   localparam int WORD_W     = 32;
   localparam int POS_W      = 32;
   localparam int BITS_W     = AXIS_COUNT;
   localparam int REP_W      = 6;
   localparam int CNT_W      = $clog2(REPEAT_LIMIT + 1);
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = PIN_W;

   localparam logic [CSR_IDX_W-1:0] REG_STEP_PIN_A = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_STEP_PIN_B = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] REG_STEP_PIN_C = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] REG_STEP_PIN_D = CSR_IDX_W'(3);
   localparam logic [CSR_IDX_W-1:0] REG_DIR_PIN_A  = CSR_IDX_W'(4);
   localparam logic [CSR_IDX_W-1:0] REG_DIR_PIN_B  = CSR_IDX_W'(5);
   localparam logic [CSR_IDX_W-1:0] REG_DIR_PIN_C  = CSR_IDX_W'(6);
   localparam logic [CSR_IDX_W-1:0] REG_DIR_PIN_D  = CSR_IDX_W'(7);

   localparam logic MODE_RUN  = 1'b0;
   localparam logic MODE_LOAD = 1'b1;

   typedef struct packed {
      logic                    mode;
      logic [BITS_W-1:0]       step_bits;
      logic [BITS_W-1:0]       dir_bits;
      logic [REP_W-1:0]        repeat_count;
      logic signed [POS_W-1:0] load_pos_a;
      logic signed [POS_W-1:0] load_pos_b;
      logic signed [POS_W-1:0] load_pos_c;
      logic signed [POS_W-1:0] load_pos_d;
   } req_item_type;

   typedef struct packed {
      logic [WORD_W-1:0]       dir_set_word;
      logic [WORD_W-1:0]       dir_clear_word;
      logic [WORD_W-1:0]       step_set_word;
      logic [WORD_W-1:0]       step_clear_word;
      logic signed [POS_W-1:0] pos_a;
      logic signed [POS_W-1:0] pos_b;
      logic signed [POS_W-1:0] pos_c;
      logic signed [POS_W-1:0] pos_d;
      logic                    last_tick;
   } rsp_item_type;

   typedef struct packed {
      logic capture;
      logic load;
      logic tick;
   } dp_cmd_type;

   typedef struct packed {
      logic last;
      logic out_free;
   } dp_status_type;

endpackage

// ----- src/sde_req_if.sv -----
// Request channel of the step/direction executor: valid/ready plus command word.
// Depends on sde_pkg.
interface sde_req_if;
   logic                            valid;
   logic                            ready;
   logic                            mode;
   logic [sde_pkg::BITS_W-1:0]      step_bits;
   logic [sde_pkg::BITS_W-1:0]      dir_bits;
   logic [sde_pkg::REP_W-1:0]       repeat_count;
   logic signed [sde_pkg::POS_W-1:0] load_pos_a;
   logic signed [sde_pkg::POS_W-1:0] load_pos_b;
   logic signed [sde_pkg::POS_W-1:0] load_pos_c;
   logic signed [sde_pkg::POS_W-1:0] load_pos_d;

   modport source (output valid, mode, step_bits, dir_bits, repeat_count,
                   load_pos_a, load_pos_b, load_pos_c, load_pos_d, input ready);
   modport sink   (input valid, mode, step_bits, dir_bits, repeat_count,
                   load_pos_a, load_pos_b, load_pos_c, load_pos_d, output ready);
endinterface

// ----- src/sde_rsp_if.sv -----
// Result channel of the step/direction executor: valid/ready plus tick word.
// Depends on sde_pkg.
interface sde_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [sde_pkg::WORD_W-1:0]       dir_set_word;
   logic [sde_pkg::WORD_W-1:0]       dir_clear_word;
   logic [sde_pkg::WORD_W-1:0]       step_set_word;
   logic [sde_pkg::WORD_W-1:0]       step_clear_word;
   logic signed [sde_pkg::POS_W-1:0] pos_a;
   logic signed [sde_pkg::POS_W-1:0] pos_b;
   logic signed [sde_pkg::POS_W-1:0] pos_c;
   logic signed [sde_pkg::POS_W-1:0] pos_d;
   logic                             last_tick;

   modport source (output valid, dir_set_word, dir_clear_word, step_set_word,
                   step_clear_word, pos_a, pos_b, pos_c, pos_d, last_tick,
                   input ready);
   modport sink   (input valid, dir_set_word, dir_clear_word, step_set_word,
                   step_clear_word, pos_a, pos_b, pos_c, pos_d, last_tick,
                   output ready);
endinterface

// ----- src/stepper_step_dir_executor.sv -----
// First tick word: after the command word is taken the controller enters RUN, then
// issues ticks into the single output register; a run command issues repeat_count + 1
// tick words, a load command none; a stalled output holds ticks.
// Reset (synchronous, high): positions zero, pins to their defaults, channels empty.
// Top level: joins the request/result channels, controller and datapath.
module stepper_step_dir_executor (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [sde_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [sde_pkg::CSR_DATA_W-1:0] csr_wdata,
   sde_req_if.sink                        req_ch,
   sde_rsp_if.source                      rsp_ch
);

   sde_pkg::req_item_type  req_item;
   sde_pkg::rsp_item_type  rsp_item;
   sde_pkg::dp_cmd_type    cmd;
   sde_pkg::dp_status_type status;
   logic                   req_ready;
   logic                   rsp_valid;

   assign req_item.mode         = req_ch.mode;
   assign req_item.step_bits    = req_ch.step_bits;
   assign req_item.dir_bits     = req_ch.dir_bits;
   assign req_item.repeat_count = req_ch.repeat_count;
   assign req_item.load_pos_a   = req_ch.load_pos_a;
   assign req_item.load_pos_b   = req_ch.load_pos_b;
   assign req_item.load_pos_c   = req_ch.load_pos_c;
   assign req_item.load_pos_d   = req_ch.load_pos_d;
   assign req_ch.ready          = req_ready;

   sde_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_mode  (req_ch.mode),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   sde_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_item  (req_item),
      .cmd       (cmd),
      .status    (status),
      .rsp_ready (rsp_ch.ready),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   assign rsp_ch.valid           = rsp_valid;
   assign rsp_ch.dir_set_word    = rsp_item.dir_set_word;
   assign rsp_ch.dir_clear_word  = rsp_item.dir_clear_word;
   assign rsp_ch.step_set_word   = rsp_item.step_set_word;
   assign rsp_ch.step_clear_word = rsp_item.step_clear_word;
   assign rsp_ch.pos_a           = rsp_item.pos_a;
   assign rsp_ch.pos_b           = rsp_item.pos_b;
   assign rsp_ch.pos_c           = rsp_item.pos_c;
   assign rsp_ch.pos_d           = rsp_item.pos_d;
   assign rsp_ch.last_tick       = rsp_item.last_tick;

endmodule

// ----- src/sde_datapath.sv -----
// Datapath: pin registers, axis positions, tick counter and the output word register.
// Depends on sde_pkg; driven by sde_ctrl through dp_cmd_type.
module sde_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [sde_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [sde_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  sde_pkg::req_item_type             req_item,
   input  sde_pkg::dp_cmd_type               cmd,
   output sde_pkg::dp_status_type            status,
   input  logic                              rsp_ready,
   output logic                              rsp_valid,
   output sde_pkg::rsp_item_type             rsp_item
);

   logic [sde_pkg::PIN_W-1:0]        step_pin_ff [sde_pkg::AXIS_COUNT];
   logic [sde_pkg::PIN_W-1:0]        dir_pin_ff  [sde_pkg::AXIS_COUNT];
   logic [sde_pkg::POS_W-1:0]        pos_ff      [sde_pkg::AXIS_COUNT];
   logic [sde_pkg::POS_W-1:0]        pos_in      [sde_pkg::AXIS_COUNT];
   logic [sde_pkg::BITS_W-1:0]       step_bits_ff;
   logic [sde_pkg::BITS_W-1:0]       dir_bits_ff;
   logic [sde_pkg::CNT_W-1:0]        ticks_left_ff;
   logic [sde_pkg::CNT_W-1:0]        ticks_left_in;
   logic [sde_pkg::REP_W:0]          ticks_wide;
   logic                             valid_ff;
   sde_pkg::rsp_item_type            out_ff;
   sde_pkg::rsp_item_type            out_in;

   // pin registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < sde_pkg::AXIS_COUNT; i++) begin
            step_pin_ff[i] <= sde_pkg::PIN_W'(i);
            dir_pin_ff[i]  <= sde_pkg::PIN_W'(i + sde_pkg::AXIS_COUNT);
         end
      end else if (csr_we) begin
         case (csr_index)
            sde_pkg::REG_STEP_PIN_A: step_pin_ff[0] <= csr_wdata;
            sde_pkg::REG_STEP_PIN_B: step_pin_ff[1] <= csr_wdata;
            sde_pkg::REG_STEP_PIN_C: step_pin_ff[2] <= csr_wdata;
            sde_pkg::REG_STEP_PIN_D: step_pin_ff[3] <= csr_wdata;
            sde_pkg::REG_DIR_PIN_A:  dir_pin_ff[0]  <= csr_wdata;
            sde_pkg::REG_DIR_PIN_B:  dir_pin_ff[1]  <= csr_wdata;
            sde_pkg::REG_DIR_PIN_C:  dir_pin_ff[2]  <= csr_wdata;
            sde_pkg::REG_DIR_PIN_D:  dir_pin_ff[3]  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // tick count, capped at the repeat limit
   always_comb begin
      ticks_wide = {1'b0, req_item.repeat_count} + (sde_pkg::REP_W + 1)'(1);
      if (ticks_wide > (sde_pkg::REP_W + 1)'(sde_pkg::REPEAT_LIMIT)) begin
         ticks_wide = (sde_pkg::REP_W + 1)'(sde_pkg::REPEAT_LIMIT);
      end
      ticks_left_in = ticks_left_ff;
      if (cmd.load) begin
         ticks_left_in = '0;
      end else if (cmd.capture) begin
         ticks_left_in = sde_pkg::CNT_W'(ticks_wide);
      end else if (cmd.tick) begin
         ticks_left_in = ticks_left_ff - sde_pkg::CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ticks_left_ff <= '0;
      end else begin
         ticks_left_ff <= ticks_left_in;
      end
      if (cmd.capture) begin
         step_bits_ff <= req_item.step_bits;
         dir_bits_ff  <= req_item.dir_bits;
      end
   end

   // pin words and next positions of one tick
   always_comb begin
      out_in = '0;
      for (int i = 0; i < sde_pkg::AXIS_COUNT; i++) begin
         if (dir_bits_ff[i]) begin
            out_in.dir_set_word = out_in.dir_set_word
                                | (sde_pkg::WORD_W'(1) << dir_pin_ff[i]);
         end else begin
            out_in.dir_clear_word = out_in.dir_clear_word
                                  | (sde_pkg::WORD_W'(1) << dir_pin_ff[i]);
         end
         if (step_bits_ff[i]) begin
            out_in.step_set_word = out_in.step_set_word
                                 | (sde_pkg::WORD_W'(1) << step_pin_ff[i]);
            pos_in[i] = pos_ff[i] + {{(sde_pkg::POS_W-1){~dir_bits_ff[i]}}, 1'b1};
         end else begin
            pos_in[i] = pos_ff[i];
         end
         out_in.step_clear_word = out_in.step_clear_word
                                | (sde_pkg::WORD_W'(1) << step_pin_ff[i]);
      end
      out_in.pos_a     = pos_in[0];
      out_in.pos_b     = pos_in[1];
      out_in.pos_c     = pos_in[2];
      out_in.pos_d     = pos_in[3];
      out_in.last_tick = status.last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < sde_pkg::AXIS_COUNT; i++) begin
            pos_ff[i] <= '0;
         end
      end else if (cmd.load) begin
         pos_ff[0] <= req_item.load_pos_a;
         pos_ff[1] <= req_item.load_pos_b;
         pos_ff[2] <= req_item.load_pos_c;
         pos_ff[3] <= req_item.load_pos_d;
      end else if (cmd.tick) begin
         pos_ff <= pos_in;
      end
   end

   // output word register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (cmd.tick) begin
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
      if (cmd.tick) begin
         out_ff <= out_in;
      end
   end

   assign status.last     = (ticks_left_ff == sde_pkg::CNT_W'(1));
   assign status.out_free = !valid_ff || rsp_ready;
   assign rsp_valid       = valid_ff;
   assign rsp_item        = out_ff;

endmodule

// ----- src/sde_ctrl.sv -----
// Controller: takes a command word; for a run command it then issues one tick per free output slot.
// Depends on sde_pkg; commands sde_datapath.
module sde_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_mode,
   output logic                    req_ready,
   input  sde_pkg::dp_status_type  status,
   output sde_pkg::dp_cmd_type     cmd
);

   typedef enum logic {
      IDLE,
      RUN
   } state_type;

   state_type state_ff;
   logic      accept;

   assign req_ready   = (state_ff == IDLE);
   assign accept      = req_valid && req_ready;
   assign cmd.capture = accept && (req_mode == sde_pkg::MODE_RUN);
   assign cmd.load    = accept && (req_mode == sde_pkg::MODE_LOAD);
   assign cmd.tick    = (state_ff == RUN) && status.out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
      end else begin
         case (state_ff)
            IDLE: begin
               if (cmd.capture) begin
                  state_ff <= RUN;
               end
            end
            RUN: begin
               if (cmd.tick && status.last) begin
                  state_ff <= IDLE;
               end
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

endmodule

// ----- src/sde_checker.sv -----
// Port-level checker of the step/direction executor, bound to the top level.
// Depends on sde_pkg and stepper_step_dir_executor_macros.svh.
`include "stepper_step_dir_executor_macros.svh"

module sde_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       req_mode,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic                       rsp_last_tick,
   input logic [sde_pkg::POS_W-1:0]  rsp_pos_a
);

   // a stalled word stays offered, with pos_a unchanged
   `SDE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `SDE_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_pos_a))
   // no new command while a command still has ticks to issue
   `SDE_ASSERT_NOW(a_busy_mid_cmd, clock, reset, rsp_valid && !rsp_last_tick, !req_ready)
   // a position load issues no word
   `SDE_ASSERT_NEXT(a_load_silent, clock, reset,
      req_valid && req_ready && req_mode == sde_pkg::MODE_LOAD && !rsp_valid, !rsp_valid)

endmodule

bind stepper_step_dir_executor sde_checker u_sde_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_ch.valid),
   .req_ready     (req_ch.ready),
   .req_mode      (req_ch.mode),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_last_tick (rsp_ch.last_tick),
   .rsp_pos_a     (rsp_ch.pos_a)
);
